// ===== hdl/dgs_pkg.sv =====
package dgs_pkg;

   localparam int TIMER_BITS_DEFAULT = 16;
   localparam int CSR_WIDTH          = 16;
   localparam int NUM_PHASES         = 6;

   localparam logic [CSR_WIDTH-1:0] HOLD_TICKS_RESET    = 16'd100;
   localparam logic [CSR_WIDTH-1:0] TIMEOUT_TICKS_RESET = 16'd600;

   // register indexes
   localparam logic CSR_HOLD_TICKS    = 1'b0;
   localparam logic CSR_TIMEOUT_TICKS = 1'b1;

   // input operations
   localparam logic OP_TICK = 1'b0;
   localparam logic OP_MODE = 1'b1;

   // modes
   localparam logic [2:0] MODE_IDLE = 3'd0;
   localparam logic [2:0] MODE_SIT  = 3'd1;
   localparam logic [2:0] MODE_FWD  = 3'd2;
   localparam logic [2:0] MODE_BWD  = 3'd3;
   localparam logic [2:0] MODE_TL   = 3'd4;
   localparam logic [2:0] MODE_TR   = 3'd5;

   // commands
   localparam logic [1:0] CMD_STATUS = 2'd0;
   localparam logic [1:0] CMD_TARGET = 2'd1;
   localparam logic [1:0] CMD_SIT    = 2'd2;
   localparam logic [1:0] CMD_HOME   = 2'd3;

   // targets
   localparam logic [2:0] TGT_LIFT  = 3'd0;
   localparam logic [2:0] TGT_HOME  = 3'd1;
   localparam logic [2:0] TGT_SFWD  = 3'd2;
   localparam logic [2:0] TGT_SHOME = 3'd3;
   localparam logic [2:0] TGT_RTURN = 3'd4;
   localparam logic [2:0] TGT_RHOME = 3'd5;

   // fixed servos
   localparam logic [2:0] SERVO_SLIDER  = 3'd4;
   localparam logic [2:0] SERVO_ROTATOR = 3'd5;

   // phases
   localparam logic [2:0] PH_LIFT_A  = 3'd0;
   localparam logic [2:0] PH_MOVE    = 3'd1;
   localparam logic [2:0] PH_LOWER_A = 3'd2;
   localparam logic [2:0] PH_LIFT_B  = 3'd3;
   localparam logic [2:0] PH_BACK    = 3'd4;
   localparam logic [2:0] PH_LOWER_B = 3'd5;

   typedef struct packed {
      logic [1:0] command;
      logic [2:0] servo;
      logic [2:0] target;
      logic [2:0] mode_now;
      logic [2:0] phase_now;
      logic       last;
   } rsp_type;

endpackage

// ===== hdl/diagonal_gait_sequencer.sv =====
// results of an accepted item are registered into the result buffer and offered from its head
// throughput: one item per cycle while the result port drains and items give one result each;
//   an item gives one or two results that leave one per cycle while rsp_ready is high, so
//   the sustained item rate is set by the single result port behind a three-entry result buffer
// reset: synchronous, active high; mode idle, phase 0, timers cleared, hold 100 and
//   timeout 600 ticks, result buffer emptied
module diagonal_gait_sequencer #(
   parameter int TIMER_BITS = dgs_pkg::TIMER_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_op,
   input  logic [2:0]                    req_new_mode,
   input  logic [5:0]                    req_reached_mask,
   input  logic                          req_all_idle,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_command,
   output logic [2:0]                    rsp_servo,
   output logic [2:0]                    rsp_target,
   output logic [2:0]                    rsp_mode_now,
   output logic [2:0]                    rsp_phase_now,
   output logic                          rsp_last,
   input  logic                          csr_we,
   input  logic                          csr_index,
   input  logic [dgs_pkg::CSR_WIDTH-1:0] csr_wdata
);

   localparam int CW = (TIMER_BITS > dgs_pkg::CSR_WIDTH) ? TIMER_BITS : dgs_pkg::CSR_WIDTH;
   localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

   logic [dgs_pkg::CSR_WIDTH-1:0] hold_ticks_ff, timeout_ticks_ff;
   logic [2:0]                    mode_ff, mode_in;
   logic [2:0]                    phase_ff, phase_in;
   logic                          started_ff, started_in;
   logic                          in_hold_ff, in_hold_in;
   logic [TIMER_BITS-1:0]         phase_elapsed_ff, phase_elapsed_in;
   logic [TIMER_BITS-1:0]         hold_elapsed_ff, hold_elapsed_in;

   dgs_pkg::rsp_type fifo_ff [3];
   dgs_pkg::rsp_type fifo_in [3];
   logic [1:0]       cnt_ff, cnt_in, cnt_pop;

   dgs_pkg::rsp_type res0, res1;
   logic             two;
   logic             accept, pop;

   // gait decode
   logic       turning, single, motion, timed_out, hold_done;
   logic [2:0] a1, b1, mover, go_t, back_t, p1, p2;
   logic [2:0] phase_next;
   logic [TIMER_BITS-1:0] he_inc, pe_inc;

   assign turning = (mode_ff == dgs_pkg::MODE_TL) || (mode_ff == dgs_pkg::MODE_TR);
   assign a1      = (mode_ff == dgs_pkg::MODE_TR) ? 3'd2 : 3'd0;
   assign b1      = (mode_ff == dgs_pkg::MODE_TR) ? 3'd0 : 3'd2;
   assign mover   = turning ? dgs_pkg::SERVO_ROTATOR : dgs_pkg::SERVO_SLIDER;
   assign go_t    = turning ? dgs_pkg::TGT_RTURN :
                    (mode_ff == dgs_pkg::MODE_FWD) ? dgs_pkg::TGT_SFWD : dgs_pkg::TGT_SHOME;
   assign back_t  = turning ? dgs_pkg::TGT_RHOME :
                    (mode_ff == dgs_pkg::MODE_FWD) ? dgs_pkg::TGT_SHOME : dgs_pkg::TGT_SFWD;

   always_comb begin
      single = 1'b0;
      if (phase_ff >= dgs_pkg::PH_LIFT_B) begin
         p1 = b1;
         p2 = b1 + 3'd1;
      end else begin
         p1 = a1;
         p2 = a1 + 3'd1;
      end
      if (phase_ff == dgs_pkg::PH_MOVE) begin
         if (turning) begin
            p1 = dgs_pkg::SERVO_ROTATOR;
            p2 = dgs_pkg::SERVO_SLIDER;
         end else begin
            p1     = mover;
            single = 1'b1;
         end
      end else if (phase_ff == dgs_pkg::PH_BACK) begin
         p1     = mover;
         single = 1'b1;
      end
   end

   assign he_inc     = (hold_elapsed_ff == TIMER_MAX) ? hold_elapsed_ff
                                                      : hold_elapsed_ff + TIMER_BITS'(1);
   assign pe_inc     = (phase_elapsed_ff == TIMER_MAX) ? phase_elapsed_ff
                                                       : phase_elapsed_ff + TIMER_BITS'(1);
   assign phase_next = (phase_ff == 3'(dgs_pkg::NUM_PHASES - 1)) ? 3'd0 : phase_ff + 3'd1;

   assign motion = single ? req_reached_mask[p1]
                          : (req_reached_mask[p1] && req_reached_mask[p2]);

   always_comb begin
      mode_in          = mode_ff;
      phase_in         = phase_ff;
      started_in       = started_ff;
      in_hold_in       = in_hold_ff;
      phase_elapsed_in = phase_elapsed_ff;
      hold_elapsed_in  = hold_elapsed_ff;
      timed_out        = 1'b0;
      hold_done        = 1'b0;
      two              = 1'b0;
      res0             = '0;
      res1             = '0;
      res0.command     = dgs_pkg::CMD_STATUS;
      res1.command     = dgs_pkg::CMD_STATUS;

      if (req_op == dgs_pkg::OP_MODE) begin
         if (req_new_mode <= dgs_pkg::MODE_TR) begin
            mode_in          = req_new_mode;
            phase_in         = dgs_pkg::PH_LIFT_A;
            started_in       = 1'b0;
            in_hold_in       = 1'b0;
            phase_elapsed_in = '0;
            hold_elapsed_in  = '0;
            unique case (req_new_mode)
               dgs_pkg::MODE_SIT:  res0.command = dgs_pkg::CMD_SIT;
               dgs_pkg::MODE_IDLE: res0.command = dgs_pkg::CMD_HOME;
               dgs_pkg::MODE_TL, dgs_pkg::MODE_TR: begin
                  res0.command = dgs_pkg::CMD_TARGET;
                  res0.servo   = dgs_pkg::SERVO_SLIDER;
                  res0.target  = dgs_pkg::TGT_SHOME;
               end
               default: res0.command = dgs_pkg::CMD_STATUS;
            endcase
         end
      end else if (mode_ff == dgs_pkg::MODE_SIT) begin
         if (req_all_idle)
            mode_in = dgs_pkg::MODE_IDLE;
      end else if (mode_ff >= dgs_pkg::MODE_FWD && mode_ff <= dgs_pkg::MODE_TR) begin
         if (in_hold_ff)
            hold_elapsed_in = he_inc;

         if (!started_ff) begin
            res0.command = dgs_pkg::CMD_TARGET;
            res1.command = dgs_pkg::CMD_TARGET;
            case (phase_ff)
               dgs_pkg::PH_LIFT_A, dgs_pkg::PH_LIFT_B: begin
                  res0.servo  = p1;
                  res0.target = dgs_pkg::TGT_LIFT;
                  res1.servo  = p2;
                  res1.target = dgs_pkg::TGT_LIFT;
                  two         = 1'b1;
               end
               dgs_pkg::PH_LOWER_A, dgs_pkg::PH_LOWER_B: begin
                  res0.servo  = p1;
                  res0.target = dgs_pkg::TGT_HOME;
                  res1.servo  = p2;
                  res1.target = dgs_pkg::TGT_HOME;
                  two         = 1'b1;
               end
               dgs_pkg::PH_MOVE: begin
                  res0.servo  = mover;
                  res0.target = go_t;
                  res1.servo  = dgs_pkg::SERVO_SLIDER;
                  res1.target = dgs_pkg::TGT_SHOME;
                  two         = turning;
               end
               default: begin
                  res0.servo  = mover;
                  res0.target = back_t;
               end
            endcase
            started_in       = 1'b1;
            phase_elapsed_in = '0;
         end else begin
            phase_elapsed_in = pe_inc;
         end

         timed_out = CW'(phase_elapsed_in) >= CW'(timeout_ticks_ff);
         if ((motion || timed_out) && !in_hold_ff) begin
            in_hold_in      = 1'b1;
            hold_elapsed_in = '0;
         end
         hold_done = CW'(hold_elapsed_in) >= CW'(hold_ticks_ff);
         if (in_hold_in && hold_done) begin
            phase_in   = phase_next;
            started_in = 1'b0;
            in_hold_in = 1'b0;
         end
      end

      res0.mode_now  = mode_in;
      res0.phase_now = phase_in;
      res0.last      = !two;
      res1.mode_now  = mode_in;
      res1.phase_now = phase_in;
      res1.last      = 1'b1;
   end

   // result buffer: read at the head, an item needs room for two beats after the pop
   assign rsp_valid = (cnt_ff != 2'd0);
   assign pop       = rsp_valid && rsp_ready;
   assign cnt_pop   = cnt_ff - {1'b0, pop};
   assign req_ready = (cnt_pop <= 2'd1);
   assign accept    = req_valid && req_ready;

   always_comb begin
      fifo_in[0] = fifo_ff[0];
      fifo_in[1] = fifo_ff[1];
      fifo_in[2] = fifo_ff[2];
      if (pop) begin
         fifo_in[0] = fifo_ff[1];
         fifo_in[1] = fifo_ff[2];
      end
      cnt_in = cnt_pop;
      if (accept) begin
         fifo_in[cnt_pop] = res0;
         if (two) begin
            fifo_in[cnt_pop + 2'd1] = res1;
            cnt_in = cnt_pop + 2'd2;
         end else begin
            cnt_in = cnt_pop + 2'd1;
         end
      end
   end

   assign rsp_command   = fifo_ff[0].command;
   assign rsp_servo     = fifo_ff[0].servo;
   assign rsp_target    = fifo_ff[0].target;
   assign rsp_mode_now  = fifo_ff[0].mode_now;
   assign rsp_phase_now = fifo_ff[0].phase_now;
   assign rsp_last      = fifo_ff[0].last;

   always_ff @(posedge clock) begin
      fifo_ff <= fifo_in;
      if (reset) begin
         cnt_ff           <= 2'd0;
         hold_ticks_ff    <= dgs_pkg::HOLD_TICKS_RESET;
         timeout_ticks_ff <= dgs_pkg::TIMEOUT_TICKS_RESET;
         mode_ff          <= dgs_pkg::MODE_IDLE;
         phase_ff         <= dgs_pkg::PH_LIFT_A;
         started_ff       <= 1'b0;
         in_hold_ff       <= 1'b0;
         phase_elapsed_ff <= '0;
         hold_elapsed_ff  <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (csr_we) begin
            unique case (csr_index)
               dgs_pkg::CSR_HOLD_TICKS:    hold_ticks_ff    <= csr_wdata;
               dgs_pkg::CSR_TIMEOUT_TICKS: timeout_ticks_ff <= csr_wdata;
               default:                    hold_ticks_ff    <= hold_ticks_ff;
            endcase
         end
         if (accept) begin
            mode_ff          <= mode_in;
            phase_ff         <= phase_in;
            started_ff       <= started_in;
            in_hold_ff       <= in_hold_in;
            phase_elapsed_ff <= phase_elapsed_in;
            hold_elapsed_ff  <= hold_elapsed_in;
         end
      end
   end

endmodule
